// File: hdl/lfps_pkg.sv
// ----------------------------------------------------------------------------
// Line-follow PID steering package
// Shared types, register indexes, reset values and fixed error values.
// ----------------------------------------------------------------------------
package lfps_pkg;

    // Chosen steering action; forward also stands for "no remembered turn".
    typedef enum logic [1:0] {
        ACT_FORWARD = 2'd0,
        ACT_LEFT    = 2'd1,
        ACT_RIGHT   = 2'd2
    } action_t;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_P         = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_I         = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_D         = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_THRESHOLD = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_THRESHOLD = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOST_THRESHOLD = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_CMD_CEILING    = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_CMD_FLOOR      = 4'd7;

    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [7:0]  turn_threshold;
        logic [7:0]  line_threshold;
        logic [7:0]  lost_threshold;
        logic [7:0]  cmd_ceiling;
        logic [7:0]  cmd_floor;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        gain_p:         16'd45875,
        gain_i:         16'd557,
        gain_d:         16'd19661,
        turn_threshold: 8'd60,
        line_threshold: 8'd185,
        lost_threshold: 8'd100,
        cmd_ceiling:    8'd157,
        cmd_floor:      8'd97
    };

    localparam int INTEGRAL_LIMIT_DEFAULT = 500;
    localparam int SERVO_BIAS             = 127;

    // Depth of the action queue between classifier and PID engine.
    localparam int QUEUE_DEPTH = 4;

    // Fixed error values of the two updates for each action.
    localparam logic signed [7:0] ERR_FWD_1   = 8'sd20;
    localparam logic signed [7:0] ERR_FWD_2   = -8'sd20;
    localparam logic signed [7:0] ERR_LEFT_1  = -8'sd23;
    localparam logic signed [7:0] ERR_LEFT_2  = -8'sd100;
    localparam logic signed [7:0] ERR_RIGHT_1 = 8'sd100;
    localparam logic signed [7:0] ERR_RIGHT_2 = 8'sd23;

endpackage

// File: hdl/line_follow_pid_steering.sv
// ----------------------------------------------------------------------------
// Line-follow PID steering
// Classifies reflectance sample pairs and produces two PID servo commands.
//
// Channel   Ports                                         Direction
// input     s_valid s_ready s_left_sample s_right_sample  in
// result    m_valid m_ready m_left_drive m_right_drive    out
//           m_action m_left_lamp m_right_lamp
// config    cfg_wvalid cfg_wready cfg_index cfg_wdata     in
//
// One sample pair is taken per cycle while the queue is not full; a result
// passes the action queue, then the integral, product and clamp stages.
// Reset (aresetn low, synchronous) restores register defaults and clears the
// integral, previous error and remembered turn.
// A stalled result holds the engine; the action queue keeps accepting input
// until it is full, then s_ready falls.
// ----------------------------------------------------------------------------
module line_follow_pid_steering #(
    parameter int INTEGRAL_LIMIT = lfps_pkg::INTEGRAL_LIMIT_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_left_sample,
    input  logic [7:0]                       s_right_sample,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_left_drive,
    output logic [7:0]                       m_right_drive,
    output logic [1:0]                       m_action,
    output logic                             m_left_lamp,
    output logic                             m_right_lamp,
    input  logic                             cfg_wvalid,
    output logic                             cfg_wready,
    input  logic [lfps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lfps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import lfps_pkg::*;

    cfg_t    cfg;
    logic    queue_full;
    logic    queue_empty;
    logic    push;
    logic    pop;
    action_t push_action;
    action_t pop_action;

    lfps_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wvalid (cfg_wvalid),
        .cfg_wready (cfg_wready),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cfg        (cfg)
    );

    lfps_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .queue_full     (queue_full),
        .push           (push),
        .push_action    (push_action)
    );

    lfps_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_action (push_action),
        .full        (queue_full),
        .pop         (pop),
        .empty       (queue_empty),
        .pop_action  (pop_action)
    );

    lfps_back #(
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .queue_empty   (queue_empty),
        .queue_action  (pop_action),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_drive  (m_left_drive),
        .m_right_drive (m_right_drive),
        .m_action      (m_action),
        .m_left_lamp   (m_left_lamp),
        .m_right_lamp  (m_right_lamp)
    );

endmodule

// File: hdl/lfps_regs.sv
// ----------------------------------------------------------------------------
// Line-follow PID steering configuration registers
// Holds gains, thresholds and servo limits written over the config channel.
// ----------------------------------------------------------------------------
module lfps_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wvalid,
    output logic                            cfg_wready,
    input  logic [lfps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lfps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output lfps_pkg::cfg_t                  cfg
);
    import lfps_pkg::*;

    cfg_t cfg_reg;

    assign cfg_wready = 1'b1;
    assign cfg        = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wvalid && cfg_wready) begin
            unique case (cfg_index)
                CFG_GAIN_P:         cfg_reg.gain_p         <= cfg_wdata;
                CFG_GAIN_I:         cfg_reg.gain_i         <= cfg_wdata;
                CFG_GAIN_D:         cfg_reg.gain_d         <= cfg_wdata;
                CFG_TURN_THRESHOLD: cfg_reg.turn_threshold <= cfg_wdata[7:0];
                CFG_LINE_THRESHOLD: cfg_reg.line_threshold <= cfg_wdata[7:0];
                CFG_LOST_THRESHOLD: cfg_reg.lost_threshold <= cfg_wdata[7:0];
                CFG_CMD_CEILING:    cfg_reg.cmd_ceiling    <= cfg_wdata[7:0];
                CFG_CMD_FLOOR:      cfg_reg.cmd_floor      <= cfg_wdata[7:0];
                default: begin
                    // Indexes beyond the register list are ignored.
                end
            endcase
        end
    end

endmodule

// File: hdl/lfps_front.sv
// ----------------------------------------------------------------------------
// Line-follow PID steering classifier
// Accepts sample pairs, picks the action and keeps the remembered turn.
// ----------------------------------------------------------------------------
module lfps_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  lfps_pkg::cfg_t    cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_left_sample,
    input  logic [7:0]        s_right_sample,
    input  logic              queue_full,
    output logic              push,
    output lfps_pkg::action_t push_action
);
    import lfps_pkg::*;

    action_t    last_turn_reg;
    action_t    last_turn_next;
    action_t    act;
    logic [7:0] mag;
    logic       lost;
    logic       centred;

    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready;

    always_comb begin
        mag = (s_left_sample >= s_right_sample) ? (s_left_sample - s_right_sample)
                                                : (s_right_sample - s_left_sample);
        lost    = (s_left_sample < cfg.lost_threshold)
               && (s_right_sample < cfg.lost_threshold);
        centred = (s_left_sample > cfg.line_threshold)
               && (s_right_sample > cfg.line_threshold);
        last_turn_next = last_turn_reg;
        if (lost) begin
            // Searching repeats the remembered turn, left when none is held.
            act = (last_turn_reg == ACT_RIGHT) ? ACT_RIGHT : ACT_LEFT;
        end else if (mag > cfg.turn_threshold) begin
            act = (s_left_sample > s_right_sample) ? ACT_LEFT : ACT_RIGHT;
            last_turn_next = act;
        end else begin
            act = ACT_FORWARD;
            if (centred) begin
                last_turn_next = ACT_FORWARD;
            end
        end
    end

    assign push_action = act;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_turn_reg <= ACT_FORWARD;
        end else if (push) begin
            last_turn_reg <= last_turn_next;
        end
    end

endmodule

// File: hdl/lfps_queue.sv
// ----------------------------------------------------------------------------
// Line-follow PID steering action queue
// Short first-in first-out buffer decoupling classifier and PID engine.
// ----------------------------------------------------------------------------
module lfps_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lfps_pkg::action_t push_action,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output lfps_pkg::action_t pop_action
);
    import lfps_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    action_t          mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty      = (count_reg == '0);
    assign pop_action = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_action;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hdl/lfps_back.sv
// ----------------------------------------------------------------------------
// Line-follow PID steering engine
// Runs the two chained PID updates of each action in a three-stage pipeline.
// ----------------------------------------------------------------------------
module lfps_back #(
    parameter int INTEGRAL_LIMIT = lfps_pkg::INTEGRAL_LIMIT_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lfps_pkg::cfg_t    cfg,
    input  logic              queue_empty,
    input  lfps_pkg::action_t queue_action,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_left_drive,
    output logic [7:0]        m_right_drive,
    output logic [1:0]        m_action,
    output logic              m_left_lamp,
    output logic              m_right_lamp
);
    import lfps_pkg::*;

    localparam int ES_W  = $clog2(INTEGRAL_LIMIT + 1) + 1;
    localparam int AW    = ((ES_W > 8) ? ES_W : 8) + 1;
    localparam int DW    = 9;
    localparam int PW    = 17 + 8;
    localparam int IW    = 17 + ES_W;
    localparam int GW    = 17 + DW;
    localparam int SUM_W = 17 + ((ES_W > DW) ? ES_W : DW) + 3;

    localparam logic signed [AW-1:0]    LIM_POS = AW'(INTEGRAL_LIMIT);
    localparam logic signed [AW-1:0]    LIM_NEG = -LIM_POS;
    localparam logic signed [SUM_W-1:0] BIAS    = SUM_W'(SERVO_BIAS * 65536);
    localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(32768);

    // Add an error to the integral and hold it within the limit.
    function automatic logic signed [ES_W-1:0] sat_add(
        input logic signed [ES_W-1:0] a,
        input logic signed [7:0]      e
    );
        logic signed [AW-1:0] t;
        t = AW'(a) + AW'(e);
        if (t > LIM_POS) begin
            t = LIM_POS;
        end else if (t < LIM_NEG) begin
            t = LIM_NEG;
        end
        return ES_W'(t);
    endfunction

    // Clamp to the servo limits, the upper test first, and round otherwise.
    function automatic logic [7:0] servo_cmd(
        input logic signed [SUM_W-1:0] s,
        input logic [7:0]              smax,
        input logic [7:0]              smin
    );
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        logic signed [SUM_W-1:0] rnd;
        hi  = $signed({{(SUM_W-24){1'b0}}, smax, 16'h0000});
        lo  = $signed({{(SUM_W-24){1'b0}}, smin, 16'h0000});
        rnd = s + HALF;
        if (s > hi) begin
            return smax;
        end else if (s < lo) begin
            return smin;
        end
        return rnd[23:16];
    endfunction

    logic                   en;
    logic signed [7:0]      e1;
    logic signed [7:0]      e2;
    logic signed [ES_W-1:0] acc1;
    logic signed [ES_W-1:0] acc2;

    logic signed [ES_W-1:0] error_sum_reg;
    logic signed [7:0]      last_error_reg;

    logic                   v1_reg;
    action_t                act1_reg;
    logic signed [7:0]      e1_reg;
    logic signed [7:0]      e2_reg;
    logic signed [ES_W-1:0] acc1_reg;
    logic signed [ES_W-1:0] acc2_reg;
    logic signed [DW-1:0]   d1_reg;
    logic signed [DW-1:0]   d2_reg;

    logic                   v2_reg;
    action_t                act2_reg;
    logic signed [PW-1:0]   pp1_reg;
    logic signed [PW-1:0]   pp2_reg;
    logic signed [IW-1:0]   pi1_reg;
    logic signed [IW-1:0]   pi2_reg;
    logic signed [GW-1:0]   pd1_reg;
    logic signed [GW-1:0]   pd2_reg;

    logic signed [SUM_W-1:0] sum1;
    logic signed [SUM_W-1:0] sum2;

    logic       m_valid_reg;
    logic [7:0] left_drive_reg;
    logic [7:0] right_drive_reg;
    action_t    action_reg;

    // The whole pipeline advances together whenever the output can take data.
    assign en  = !m_valid_reg || m_ready;
    assign pop = en && !queue_empty;

    always_comb begin
        unique case (queue_action)
            ACT_LEFT: begin
                e1 = ERR_LEFT_1;
                e2 = ERR_LEFT_2;
            end
            ACT_RIGHT: begin
                e1 = ERR_RIGHT_1;
                e2 = ERR_RIGHT_2;
            end
            default: begin
                e1 = ERR_FWD_1;
                e2 = ERR_FWD_2;
            end
        endcase
        acc1 = sat_add(error_sum_reg, e1);
        acc2 = sat_add(acc1, e2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end else if (pop) begin
            error_sum_reg  <= acc2;
            last_error_reg <= e2;
        end
    end

    // Stage one: errors, clamped integrals and error differences.
    always_ff @(posedge aclk) begin
        if (en) begin
            act1_reg <= queue_action;
            e1_reg   <= e1;
            e2_reg   <= e2;
            acc1_reg <= acc1;
            acc2_reg <= acc2;
            d1_reg   <= DW'(e1) - DW'(last_error_reg);
            d2_reg   <= DW'(e2) - DW'(e1);
        end
    end

    // Stage two: the six gain products.
    always_ff @(posedge aclk) begin
        if (en) begin
            act2_reg <= act1_reg;
            pp1_reg  <= $signed({1'b0, cfg.gain_p}) * e1_reg;
            pp2_reg  <= $signed({1'b0, cfg.gain_p}) * e2_reg;
            pi1_reg  <= $signed({1'b0, cfg.gain_i}) * acc1_reg;
            pi2_reg  <= $signed({1'b0, cfg.gain_i}) * acc2_reg;
            pd1_reg  <= $signed({1'b0, cfg.gain_d}) * d1_reg;
            pd2_reg  <= $signed({1'b0, cfg.gain_d}) * d2_reg;
        end
    end

    assign sum1 = SUM_W'(pp1_reg) + SUM_W'(pi1_reg) + SUM_W'(pd1_reg) + BIAS;
    assign sum2 = SUM_W'(pp2_reg) + SUM_W'(pi2_reg) + SUM_W'(pd2_reg) + BIAS;

    // Stage three: sums, servo clamps and the output register.
    always_ff @(posedge aclk) begin
        if (en) begin
            left_drive_reg  <= servo_cmd(sum1, cfg.cmd_ceiling, cfg.cmd_floor);
            right_drive_reg <= servo_cmd(sum2, cfg.cmd_ceiling, cfg.cmd_floor);
            action_reg      <= act2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= pop;
            v2_reg      <= v1_reg;
            m_valid_reg <= v2_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_left_drive  = left_drive_reg;
    assign m_right_drive = right_drive_reg;
    assign m_action      = action_reg;
    assign m_left_lamp   = (action_reg == ACT_LEFT);
    assign m_right_lamp  = (action_reg == ACT_RIGHT);

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line-follow PID steering testbench
// Drives reflectance sample pairs and register writes into the steering
// block. Every accepted pair is run through a local model of the classifier
// and the two chained PID updates. Each result transfer is compared field by
// field with the oldest predicted result. Both sides idle at random, and one
// long receiver hold-off fills the block until it stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
    import lfps_pkg::*;

    localparam int IDLE_PCT      = 36;
    localparam int PIPE_LATENCY  = 3;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 4;
    localparam int HOLD_CYCLES   = 80;
    localparam int PHASE_COUNT   = 10;
    localparam int PHASE_ITEMS   = 100;
    localparam int TIMEOUT_NS    = 4_000_000;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = CFG_CMD_FLOOR + 1'b1;

    typedef struct {
        logic [7:0] left_drive;
        logic [7:0] right_drive;
        action_t    action;
        logic       left_lamp;
        logic       right_lamp;
    } steer_result_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_left_sample = '0;
    logic [7:0]             s_right_sample = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [7:0]             m_left_drive;
    logic [7:0]             m_right_drive;
    logic [1:0]             m_action;
    logic                   m_left_lamp;
    logic                   m_right_lamp;
    logic                   cfg_wvalid = 1'b0;
    logic                   cfg_wready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Local copy of the register file and the controller state.
    cfg_t    shadow_cfg = CFG_RESET;
    int      integral = 0;
    int      err_last = 0;
    action_t turn_memory = ACT_FORWARD;

    steer_result_t pending_steer[$];
    int            fail_count = 0;
    bit            steady = 1'b0;
    int            hold_requests = 0;
    int            hold_seen = 0;
    int            hold_left = 0;

    line_follow_pid_steering u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_sample  (s_left_sample),
        .s_right_sample (s_right_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_drive   (m_left_drive),
        .m_right_drive  (m_right_drive),
        .m_action       (m_action),
        .m_left_lamp    (m_left_lamp),
        .m_right_lamp   (m_right_lamp),
        .cfg_wvalid     (cfg_wvalid),
        .cfg_wready     (cfg_wready),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // One PID update: clamped integral, Q16 sum with bias, clamp and round.
    function automatic logic [7:0] pid_command(int err);
        int     acc;
        longint sum;
        longint upper;
        longint lower;
        acc = integral + err;
        if (acc > INTEGRAL_LIMIT_DEFAULT) begin
            acc = INTEGRAL_LIMIT_DEFAULT;
        end else if (acc < -INTEGRAL_LIMIT_DEFAULT) begin
            acc = -INTEGRAL_LIMIT_DEFAULT;
        end
        integral = acc;
        sum = longint'(shadow_cfg.gain_p) * err
            + longint'(shadow_cfg.gain_i) * acc
            + longint'(shadow_cfg.gain_d) * (err - err_last)
            + longint'(SERVO_BIAS) * 65536;
        err_last = err;
        upper = longint'(shadow_cfg.cmd_ceiling) * 65536;
        lower = longint'(shadow_cfg.cmd_floor) * 65536;
        if (sum > upper) return shadow_cfg.cmd_ceiling;
        if (sum < lower) return shadow_cfg.cmd_floor;
        return 8'((sum + 32768) >>> 16);
    endfunction

    function automatic steer_result_t steer_step(logic [7:0] left, logic [7:0] right);
        steer_result_t res;
        int            diff;
        int            mag;
        action_t       act;
        int            err_a;
        int            err_b;
        diff = int'(left) - int'(right);
        mag  = (diff < 0) ? -diff : diff;
        if (left < shadow_cfg.lost_threshold && right < shadow_cfg.lost_threshold) begin
            // Line lost: keep searching the way we last turned, left by default.
            act = (turn_memory == ACT_RIGHT) ? ACT_RIGHT : ACT_LEFT;
        end else if (mag > int'(shadow_cfg.turn_threshold)) begin
            act = (diff > 0) ? ACT_LEFT : ACT_RIGHT;
            turn_memory = act;
        end else begin
            act = ACT_FORWARD;
            if (left > shadow_cfg.line_threshold && right > shadow_cfg.line_threshold) begin
                turn_memory = ACT_FORWARD;
            end
        end
        case (act)
            ACT_LEFT: begin
                err_a = int'(ERR_LEFT_1);
                err_b = int'(ERR_LEFT_2);
            end
            ACT_RIGHT: begin
                err_a = int'(ERR_RIGHT_1);
                err_b = int'(ERR_RIGHT_2);
            end
            default: begin
                err_a = int'(ERR_FWD_1);
                err_b = int'(ERR_FWD_2);
            end
        endcase
        res.left_drive  = pid_command(err_a);
        res.right_drive = pid_command(err_b);
        res.action      = act;
        res.left_lamp   = (act == ACT_LEFT);
        res.right_lamp  = (act == ACT_RIGHT);
        return res;
    endfunction

    function automatic void shadow_write(logic [CFG_INDEX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GAIN_P:         shadow_cfg.gain_p = data;
            CFG_GAIN_I:         shadow_cfg.gain_i = data;
            CFG_GAIN_D:         shadow_cfg.gain_d = data;
            CFG_TURN_THRESHOLD: shadow_cfg.turn_threshold = data[7:0];
            CFG_LINE_THRESHOLD: shadow_cfg.line_threshold = data[7:0];
            CFG_LOST_THRESHOLD: shadow_cfg.lost_threshold = data[7:0];
            CFG_CMD_CEILING:    shadow_cfg.cmd_ceiling = data[7:0];
            CFG_CMD_FLOOR:      shadow_cfg.cmd_floor = data[7:0];
            default: ;
        endcase
    endfunction

    task automatic send_pair(logic [7:0] left, logic [7:0] right);
        int gap;
        gap = 0;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_left_sample  <= left;
        s_right_sample <= right;
        do @(posedge aclk); while (!s_ready);
        pending_steer.push_back(steer_step(left, right));
    endtask

    // Stop offering pairs, wait for every predicted result, then let the
    // pipeline settle so that a register write lands on an idle block.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_steer.size() > 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wvalid <= 1'b1;
        cfg_index  <= idx;
        cfg_wdata  <= data;
        do @(posedge aclk); while (!cfg_wready);
        shadow_write(idx, data);
        cfg_wvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Byte registers get random upper bits so that the masking is exercised.
    task automatic set_config(cfg_t c);
        write_reg(CFG_GAIN_P, c.gain_p);
        write_reg(CFG_GAIN_I, c.gain_i);
        write_reg(CFG_GAIN_D, c.gain_d);
        write_reg(CFG_TURN_THRESHOLD, {8'($urandom), c.turn_threshold});
        write_reg(CFG_LINE_THRESHOLD, {8'($urandom), c.line_threshold});
        write_reg(CFG_LOST_THRESHOLD, {8'($urandom), c.lost_threshold});
        write_reg(CFG_CMD_CEILING, {8'($urandom), c.cmd_ceiling});
        write_reg(CFG_CMD_FLOOR, {8'($urandom), c.cmd_floor});
    endtask

    task automatic send_probe_set();
        send_pair(8'd0, 8'd0);
        send_pair(8'd255, 8'd255);
        send_pair(8'd255, 8'd0);
        send_pair(8'd0, 8'd255);
        send_pair(8'd30, 8'd200);
        send_pair(8'd200, 8'd30);
        send_pair(8'd128, 8'd128);
        send_pair(8'd254, 8'd1);
    endtask

    function automatic logic [15:0] pick_gain(logic [15:0] dflt);
        case ($urandom_range(0, 3))
            0: return dflt;
            1: return 16'($urandom);
            2: return 16'($urandom_range(0, 4095));
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.gain_p = pick_gain(CFG_RESET.gain_p);
        c.gain_i = pick_gain(CFG_RESET.gain_i);
        c.gain_d = pick_gain(CFG_RESET.gain_d);
        c.turn_threshold = 8'($urandom_range(0, 150));
        c.lost_threshold = 8'($urandom_range(20, 160));
        c.line_threshold = 8'($urandom_range(120, 254));
        if ($urandom_range(0, 99) < 85) begin
            c.cmd_floor   = 8'($urandom_range(0, 200));
            c.cmd_ceiling = 8'($urandom_range(c.cmd_floor, 255));
        end else begin
            c.cmd_floor   = 8'($urandom);
            c.cmd_ceiling = 8'($urandom);
        end
        return c;
    endfunction

    // Sample pairs aimed at each decision region under the current settings.
    function automatic void pick_pair(output logic [7:0] left, output logic [7:0] right);
        int a;
        int b;
        int tt;
        int d;
        int sel;
        tt  = shadow_cfg.turn_threshold;
        a   = $urandom_range(0, 255);
        b   = $urandom_range(0, 255);
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            if (shadow_cfg.lost_threshold > 0) begin
                a = $urandom_range(0, shadow_cfg.lost_threshold - 1);
                b = $urandom_range(0, shadow_cfg.lost_threshold - 1);
            end
        end else if (sel < 45) begin
            if (a > tt) begin
                b = $urandom_range(0, a - tt - 1);
            end else if (a + tt < 255) begin
                b = $urandom_range(a + tt + 1, 255);
            end
        end else if (sel < 60) begin
            // Difference right on the turn threshold or just past it.
            d = tt + $urandom_range(0, 1);
            if (a + d <= 255) begin
                b = a + d;
            end else if (a - d >= 0) begin
                b = a - d;
            end
        end else if (sel < 80) begin
            if (shadow_cfg.line_threshold < 255) begin
                a = $urandom_range(shadow_cfg.line_threshold + 1, 255);
                b = $urandom_range(shadow_cfg.line_threshold + 1, 255);
            end
        end
        if ($urandom_range(0, 1)) begin
            left  = 8'(a);
            right = 8'(b);
        end else begin
            left  = 8'(b);
            right = 8'(a);
        end
    endfunction

    // Receiver: random idling, with a counted hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        steer_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_steer.size() == 0) begin
                $error("result transfer with no prediction waiting");
                fail_count++;
            end else begin
                want = pending_steer.pop_front();
                if (m_left_drive !== want.left_drive) begin
                    $error("left_drive mismatch: expected %0d, actual %0d",
                           want.left_drive, m_left_drive);
                    fail_count++;
                end
                if (m_right_drive !== want.right_drive) begin
                    $error("right_drive mismatch: expected %0d, actual %0d",
                           want.right_drive, m_right_drive);
                    fail_count++;
                end
                if (m_action !== want.action) begin
                    $error("action mismatch: expected %0d, actual %0d",
                           want.action, m_action);
                    fail_count++;
                end
                if (m_left_lamp !== want.left_lamp) begin
                    $error("left_lamp mismatch: expected %0d, actual %0d",
                           want.left_lamp, m_left_lamp);
                    fail_count++;
                end
                if (m_right_lamp !== want.right_lamp) begin
                    $error("right_lamp mismatch: expected %0d, actual %0d",
                           want.right_lamp, m_right_lamp);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_default_decisions();
        send_pair(8'd0, 8'd0);        // lost with no remembered turn: left
        send_pair(8'd255, 8'd255);    // centred: clears the memory
        send_pair(8'd255, 8'd0);
        send_pair(8'd0, 8'd255);
        send_pair(8'd50, 8'd50);      // lost after a right turn: right
        send_pair(8'd160, 8'd100);    // difference equal to threshold: forward
        send_pair(8'd99, 8'd99);
        send_pair(8'd100, 8'd99);     // one sample on the lost threshold
        send_pair(8'd161, 8'd100);
        send_pair(8'd186, 8'd186);
        send_pair(8'd20, 8'd30);
        send_pair(8'd40, 8'd200);
        send_pair(8'd185, 8'd200);    // forward on the line threshold keeps right
        send_pair(8'd10, 8'd10);
        // Long runs each way; the right-turn run drives the integral into its upper clamp.
        repeat (6) send_pair(8'd0, 8'd200);
        repeat (6) send_pair(8'd200, 8'd0);
        send_pair(8'd128, 8'd128);
        drain();
    endtask

    task automatic test_register_extremes();
        cfg_t c;
        int   i;
        c = CFG_RESET;
        c.gain_p = 16'hFFFF;
        c.gain_i = 16'hFFFF;
        c.gain_d = 16'hFFFF;
        set_config(c);
        send_probe_set();
        drain();
        c.cmd_ceiling = 8'd255;
        c.cmd_floor   = 8'd0;
        set_config(c);
        send_probe_set();
        drain();
        c.gain_p = 16'h0000;
        c.gain_i = 16'h0000;
        c.gain_d = 16'h0000;
        set_config(c);
        send_probe_set();
        drain();
        c = CFG_RESET;
        c.turn_threshold = 8'd0;
        c.line_threshold = 8'd0;
        c.lost_threshold = 8'd0;
        set_config(c);
        send_probe_set();
        drain();
        c.turn_threshold = 8'd255;
        c.line_threshold = 8'd255;
        c.lost_threshold = 8'd255;
        set_config(c);
        send_probe_set();
        drain();
        // Crossed clamps: minimum above maximum.
        c = CFG_RESET;
        c.cmd_ceiling = 8'd90;
        c.cmd_floor   = 8'd200;
        set_config(c);
        send_probe_set();
        drain();
        // Writes past the last register must leave the settings alone.
        for (i = CFG_FIRST_UNUSED; i < (1 << CFG_INDEX_W); i++) begin
            write_reg(CFG_INDEX_W'(i), 16'($urandom) | 16'h8001);
        end
        write_reg(CFG_INDEX_W'((1 << CFG_INDEX_W) - 1), 16'hFFFF);
        send_probe_set();
        drain();
        set_config(CFG_RESET);
    endtask

    task automatic test_backpressure();
        logic [7:0] left;
        logic [7:0] right;
        steady = 1'b1;
        hold_requests++;
        repeat (30) begin
            pick_pair(left, right);
            send_pair(left, right);
        end
        steady = 1'b0;
        // The sender waits here until every result has come back.
        drain();
    endtask

    task automatic test_random_traffic();
        logic [7:0] left;
        logic [7:0] right;
        int         phase;
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase == 0) begin
                set_config(CFG_RESET);
            end else begin
                set_config(random_config());
            end
            steady = (phase == 4);
            repeat (PHASE_ITEMS) begin
                pick_pair(left, right);
                send_pair(left, right);
            end
            steady = 1'b0;
            drain();
        end
    endtask

    initial begin
        int guard;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_decisions();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        s_valid <= 1'b0;
        guard = 0;
        while (pending_steer.size() > 0 && guard < 10000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_steer.size() > 0) begin
            $error("%0d predicted results never arrived", pending_steer.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
